### rtl/tsm_pkg.sv
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants for the two-stack shared memory unit.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int DEPTH       = 32;
  localparam int MAX_RESULTS = 32;
  localparam int WORD_W      = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  // Longest dump run; a stack never holds more than DEPTH words.
  localparam int DUMP_MAX    = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

  typedef enum logic [2:0] {
    CMD_PUSH_LO = 3'd0,
    CMD_PUSH_UP = 3'd1,
    CMD_POP_LO  = 3'd2,
    CMD_POP_UP  = 3'd3,
    CMD_DUMP_LO = 3'd4,
    CMD_DUMP_UP = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_OVERFLOW  = 2'd1,
    STS_UNDERFLOW = 2'd2,
    STS_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_ONES,
    SRC_RAM
  } src_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_WAIT,
    ST_DUMP_RD,
    ST_DUMP_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    push_lo;
    logic    push_up;
    logic    pop_lo;
    logic    pop_up;
    logic    dump_start;
    logic    dump_upper;
    logic    dump_rd;
    logic    dump_next;
    logic    out_load;
    src_t    out_src;
    status_t out_status;
    logic    out_last;
  } tsm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic lower_empty;
    logic upper_empty;
    logic dump_last;
    logic out_free;
  } tsm_sts_t;

endpackage

### rtl/tsm_ram.sv
// ----------------------------------------------------------------------------
// tsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/tsm_datapath.sv
// ----------------------------------------------------------------------------
// tsm_datapath
// Stack counters, shared RAM, dump sequencing and the result register.
// ----------------------------------------------------------------------------
module tsm_datapath
  import tsm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  tsm_cmd_t                 cmd,
  output tsm_sts_t                 sts,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] out_data,
  output status_t                  out_status,
  output logic                     out_last
);

  localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_DMAX  = CNT_W'(DUMP_MAX);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  logic [CNT_W-1:0]  count_lower_r, count_lower_nxt;
  logic [CNT_W-1:0]  count_upper_r, count_upper_nxt;
  logic [CNT_W-1:0]  dump_idx_r, dump_idx_nxt;
  logic [CNT_W-1:0]  dump_n_r, dump_n_nxt;
  logic              dump_upper_r, dump_upper_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_data_r, out_data_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  logic [CNT_W-1:0]  dump_cnt;
  logic [CNT_W-1:0]  up_push_pos;
  logic [CNT_W-1:0]  up_top_pos;
  logic [CNT_W-1:0]  up_dump_pos;
  logic [CNT_W-1:0]  rd_pos;
  logic [CNT_W-1:0]  wr_pos;
  logic              ram_we;
  logic              ram_re;
  logic [WORD_W-1:0] ram_rdata;

  always_comb begin
    sts.full        = ({1'b0, count_lower_r} + {1'b0, count_upper_r}) >= SUM_W'(DEPTH);
    sts.lower_empty = (count_lower_r == '0);
    sts.upper_empty = (count_upper_r == '0);
    sts.dump_last   = (dump_idx_r == (dump_n_r - CNT_ONE));
    sts.out_free    = !out_valid_r || out_ready;
  end

  // Stack two positions, counted from the top of the memory
  assign up_push_pos = CNT_DEPTH - count_upper_r - CNT_ONE;
  assign up_top_pos  = CNT_DEPTH - count_upper_r;
  assign up_dump_pos = CNT_DEPTH - CNT_ONE - dump_idx_r;

  always_comb begin
    ram_we = cmd.push_lo || cmd.push_up;
    wr_pos = cmd.push_up ? up_push_pos : count_lower_r;
    ram_re = cmd.pop_lo || cmd.pop_up || cmd.dump_rd;
    if (cmd.pop_lo) begin
      rd_pos = count_lower_r - CNT_ONE;
    end else if (cmd.pop_up) begin
      rd_pos = up_top_pos;
    end else if (dump_upper_r) begin
      rd_pos = up_dump_pos;
    end else begin
      rd_pos = dump_idx_r;
    end
  end

  tsm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_pos[ADDR_W-1:0]),
    .wdata(push_value),
    .re   (ram_re),
    .raddr(rd_pos[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    dump_cnt = cmd.dump_upper ? count_upper_r : count_lower_r;

    count_lower_nxt = count_lower_r;
    if (cmd.push_lo) begin
      count_lower_nxt = count_lower_r + CNT_ONE;
    end else if (cmd.pop_lo) begin
      count_lower_nxt = count_lower_r - CNT_ONE;
    end

    count_upper_nxt = count_upper_r;
    if (cmd.push_up) begin
      count_upper_nxt = count_upper_r + CNT_ONE;
    end else if (cmd.pop_up) begin
      count_upper_nxt = count_upper_r - CNT_ONE;
    end

    dump_idx_nxt   = dump_idx_r;
    dump_n_nxt     = dump_n_r;
    dump_upper_nxt = dump_upper_r;
    if (cmd.dump_start) begin
      dump_idx_nxt   = '0;
      dump_n_nxt     = (dump_cnt > CNT_DMAX) ? CNT_DMAX : dump_cnt;
      dump_upper_nxt = cmd.dump_upper;
    end else if (cmd.dump_next) begin
      dump_idx_nxt = dump_idx_r + CNT_ONE;
    end

    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (cmd.out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = cmd.out_status;
      out_last_nxt   = cmd.out_last;
      case (cmd.out_src)
        SRC_ZERO: out_data_nxt = '0;
        SRC_ONES: out_data_nxt = '1;
        SRC_RAM:  out_data_nxt = ram_rdata;
        default:  out_data_nxt = '0;
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_lower_r <= '0;
      count_upper_r <= '0;
      dump_idx_r    <= '0;
      dump_n_r      <= '0;
      dump_upper_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      count_lower_r <= count_lower_nxt;
      count_upper_r <= count_upper_nxt;
      dump_idx_r    <= dump_idx_nxt;
      dump_n_r      <= dump_n_nxt;
      dump_upper_r  <= dump_upper_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

### rtl/tsm_ctrl.sv
// ----------------------------------------------------------------------------
// tsm_ctrl
// Command decode and sequencing for pops and dumps.
// ----------------------------------------------------------------------------
module tsm_ctrl
  import tsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_command,
  input  tsm_sts_t   sts,
  output tsm_cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.out_src    = SRC_ZERO;
          cmd.out_status = STS_OK;
          cmd.out_last   = 1'b1;
          case (cmd_t'(in_command))
            CMD_PUSH_LO, CMD_PUSH_UP: begin
              cmd.out_load = 1'b1;
              if (sts.full) begin
                cmd.out_status = STS_OVERFLOW;
              end else if (cmd_t'(in_command) == CMD_PUSH_LO) begin
                cmd.push_lo = 1'b1;
              end else begin
                cmd.push_up = 1'b1;
              end
            end
            CMD_POP_LO: begin
              if (sts.lower_empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_src    = SRC_ONES;
                cmd.out_status = STS_UNDERFLOW;
              end else begin
                cmd.pop_lo = 1'b1;
                state_nxt  = ST_POP_WAIT;
              end
            end
            CMD_POP_UP: begin
              if (sts.upper_empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_src    = SRC_ONES;
                cmd.out_status = STS_UNDERFLOW;
              end else begin
                cmd.pop_up = 1'b1;
                state_nxt  = ST_POP_WAIT;
              end
            end
            CMD_DUMP_LO: begin
              if (sts.lower_empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = STS_EMPTY;
              end else begin
                cmd.dump_start = 1'b1;
                state_nxt      = ST_DUMP_RD;
              end
            end
            CMD_DUMP_UP: begin
              cmd.dump_upper = 1'b1;
              if (sts.upper_empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = STS_EMPTY;
              end else begin
                cmd.dump_start = 1'b1;
                state_nxt      = ST_DUMP_RD;
              end
            end
            default: begin
              // unused codes: drop the word
            end
          endcase
        end
      end
      ST_POP_WAIT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_src    = SRC_RAM;
          cmd.out_status = STS_OK;
          cmd.out_last   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_DUMP_RD: begin
        cmd.dump_rd = 1'b1;
        state_nxt   = ST_DUMP_OUT;
      end
      ST_DUMP_OUT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_src    = SRC_RAM;
          cmd.out_status = STS_OK;
          cmd.out_last   = sts.dump_last;
          if (sts.dump_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.dump_next = 1'b1;
            state_nxt     = ST_DUMP_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/two_stacks_shared_memory_unit.sv
// ----------------------------------------------------------------------------
// two_stacks_shared_memory_unit
// Two stacks in one shared RAM, driven by a stream of command words.
// ----------------------------------------------------------------------------
// Two stacks share one RAM of DEPTH 32-bit words: stack one grows up from
// word 0, stack two grows down from word DEPTH-1, and a push is refused with
// an overflow status once the two together fill the RAM. Each input word
// carries a command in in_tuser and a push value in in_tdata. Every push,
// pop or empty-stack command gives exactly one result word with tlast set;
// a dump streams the chosen stack (stack one bottom to top, stack two from
// the RAM end inward), at most 32 words, with tlast on the final one.
// Unused command codes are taken and give no result. The RAM has one write
// and one registered read port: a push, a refused push or an underflow loads
// its result as the word is taken, a pop reads the RAM and then loads the
// result, and a dump takes the word, then does a read and a load per dumped
// word, during which no input word is taken.
// A result waits in the output register; in_tready drops while that
// register is full and not being drained.
// ----------------------------------------------------------------------------
module two_stacks_shared_memory_unit
  import tsm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic signed [WORD_W-1:0] in_tdata,  // [31:0] push_value
  input  logic [2:0]               in_tuser,  // [2:0] command
  // result channel
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic signed [WORD_W-1:0] out_tdata, // [31:0] data_word
  output logic [1:0]               out_tuser, // [1:0] status
  output logic                     out_tlast  // last_of_run
);

  tsm_cmd_t cmd;
  tsm_sts_t sts;
  status_t  out_status;

  // Sequence the command words and the dump stream
  tsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_command(in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the counters, the shared RAM and the output register
  tsm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .push_value(in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_status(out_status),
    .out_last  (out_tlast)
  );

  assign out_tuser = out_status;

endmodule

### rtl/tsm_checker.sv
// ----------------------------------------------------------------------------
// tsm_checker
// Port-level checks on the result channel of the two-stack unit.
// ----------------------------------------------------------------------------
module tsm_checker
  import tsm_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic signed [WORD_W-1:0] out_tdata,
  input logic [1:0]               out_tuser,
  input logic                     out_tlast
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // Reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Underflow returns all ones and ends the run
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STS_UNDERFLOW) |-> (out_tdata == -32'sd1) && out_tlast)
    else $error("underflow word malformed");

  // Overflow and empty dump return zero and end the run
  a_zero_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == STS_OVERFLOW) || (out_tuser == STS_EMPTY))
      |-> (out_tdata == '0) && out_tlast)
    else $error("overflow or empty word malformed");

  // An input word never enters while an unaccepted dump word waits mid-run
  a_no_take_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !(in_tvalid && in_tready))
    else $error("input taken during a dump");

endmodule

bind two_stacks_shared_memory_unit tsm_checker u_tsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-stack shared memory unit.
// ----------------------------------------------------------------------------
// Commands go in as stream words. Every accepted word is run through a local
// mirror of both stacks, which queues the result words the unit must give.
// A monitor pops that queue on each accepted result and compares data,
// status and tlast. A directed part covers the empty stacks, extreme values,
// a full memory from both sides and the longest dumps. A random part then
// alternates between filling and draining mixes. Sender gaps and receiver
// stalls vary from one segment to the next.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsm_pkg::*;

  localparam int          STREAM_ITEMS = 310;  // stop random traffic here
  localparam int          SETTLE_CYC   = 4 * DUMP_MAX;
  localparam int          SHOW_MAX     = 10;
  // Spare codes: taken by the unit, no result and no state change.
  localparam logic [2:0]  CMD_SPARE_6  = 3'd6;
  localparam logic [2:0]  CMD_SPARE_7  = 3'd7;

  typedef struct {
    logic signed [WORD_W-1:0] word;
    status_t                  status;
    logic                     last;
  } stack_result_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic signed [WORD_W-1:0] in_tdata = '0;   // [31:0] push_value
  logic [2:0]               in_tuser = '0;   // [2:0] command
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic signed [WORD_W-1:0] out_tdata;       // [31:0] data_word
  logic [1:0]               out_tuser;       // [1:0] status
  logic                     out_tlast;       // last_of_run

  // Mirror of the unit's state
  logic signed [WORD_W-1:0] mirror_mem [DEPTH];
  int                       lower_count;
  int                       upper_count;

  stack_result_t            pending_results[$];
  int                       mismatch_count = 0;
  int                       words_sent = 0;

  // Sender pacing and receiver stall pattern
  int                       max_gap = 0;
  int                       burst_left = 0;
  bit                       rx_always_ready = 1'b1;
  logic [15:0]              rx_pattern = 16'hFFFF;
  int                       rx_phase = 0;

  two_stacks_shared_memory_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // Receiver: rotate a 16-bit ready pattern, replaced by a fresh random one periodically
  always @(negedge clk) begin
    if (rx_phase % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: rx_pattern = 16'hFFFF;
        1: rx_pattern = 16'($urandom) | 16'h0001;
        2: rx_pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
        default: rx_pattern = 16'($urandom) | 16'($urandom) | 16'h0001;
      endcase
    end
    out_tready = rx_always_ready ? 1'b1 : rx_pattern[rx_phase % 16];
    rx_phase++;
  end

  // Expected results for one accepted command, from the mirrored stacks
  function automatic void predict_stack_results(logic [2:0] code,
                                                logic signed [WORD_W-1:0] value);
    stack_result_t r;
    int            run_len;
    bit            upper;
    r.word   = '0;
    r.status = STS_OK;
    r.last   = 1'b1;
    case (code)
      CMD_PUSH_LO, CMD_PUSH_UP: begin
        if (lower_count + upper_count >= DEPTH) begin
          r.status = STS_OVERFLOW;
        end else if (code == CMD_PUSH_LO) begin
          mirror_mem[lower_count] = value;
          lower_count++;
        end else begin
          upper_count++;
          mirror_mem[DEPTH - upper_count] = value;
        end
        pending_results.push_back(r);
      end
      CMD_POP_LO: begin
        if (lower_count == 0) begin
          r.word   = -1;
          r.status = STS_UNDERFLOW;
        end else begin
          lower_count--;
          r.word = mirror_mem[lower_count];
        end
        pending_results.push_back(r);
      end
      CMD_POP_UP: begin
        if (upper_count == 0) begin
          r.word   = -1;
          r.status = STS_UNDERFLOW;
        end else begin
          r.word = mirror_mem[DEPTH - upper_count];
          upper_count--;
        end
        pending_results.push_back(r);
      end
      CMD_DUMP_LO, CMD_DUMP_UP: begin
        upper   = (code == CMD_DUMP_UP);
        run_len = upper ? upper_count : lower_count;
        if (run_len == 0) begin
          r.status = STS_EMPTY;
          pending_results.push_back(r);
        end else begin
          if (run_len > MAX_RESULTS) run_len = MAX_RESULTS;
          // stack one bottom up, stack two from the memory end inward
          for (int i = 0; i < run_len; i++) begin
            r.word = upper ? mirror_mem[DEPTH - 1 - i] : mirror_mem[i];
            r.last = (i == run_len - 1);
            pending_results.push_back(r);
          end
        end
      end
      default: ;  // spare codes: drop silently
    endcase
  endfunction

  // Send one command word; hold it until the unit takes it
  task automatic send_word(logic [2:0] code, logic signed [WORD_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        in_tdata  = $urandom;
        in_tuser  = 3'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = value;
    in_tuser  = code;
    do @(posedge clk); while (!in_tready);
    predict_stack_results(code, value);
    words_sent++;
  endtask

  // Lower valid and hold off until every expected result has arrived
  task automatic wait_results_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Set sender gaps and receiver stalls for the next stretch of traffic
  task automatic shuffle_pacing();
    max_gap         = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    rx_always_ready = ($urandom_range(0, 3) == 0);
    burst_left      = 0;
  endtask

  function automatic logic [2:0] pick_command(traffic_mix_t mix);
    int roll;
    int push_pct;
    int pop_pct;
    roll     = $urandom_range(0, 99);
    push_pct = (mix == MIX_FILL) ? 65 : (mix == MIX_DRAIN) ? 20 : 42;
    pop_pct  = (mix == MIX_DRAIN) ? 65 : (mix == MIX_FILL) ? 20 : 42;
    if (roll < push_pct) return $urandom_range(0, 1) ? CMD_PUSH_UP : CMD_PUSH_LO;
    roll -= push_pct;
    if (roll < pop_pct) return $urandom_range(0, 1) ? CMD_POP_UP : CMD_POP_LO;
    roll -= pop_pct;
    if (roll < 11) return $urandom_range(0, 1) ? CMD_DUMP_UP : CMD_DUMP_LO;
    return $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
  endfunction

  // Pops, dumps and spare codes on two empty stacks
  task automatic test_empty_stacks();
    send_word(CMD_POP_LO, $urandom);
    send_word(CMD_POP_UP, $urandom);
    send_word(CMD_DUMP_LO, $urandom);
    send_word(CMD_DUMP_UP, $urandom);
    send_word(CMD_SPARE_6, $urandom);
    send_word(CMD_SPARE_7, $urandom);
  endtask

  // Most positive, most negative, zero and all-ones through both stacks
  task automatic test_extreme_values();
    send_word(CMD_PUSH_LO, 32'sh7FFF_FFFF);
    send_word(CMD_PUSH_UP, 32'sh8000_0000);
    send_word(CMD_PUSH_LO, 32'sh0000_0000);
    send_word(CMD_PUSH_UP, 32'shFFFF_FFFF);
    send_word(CMD_DUMP_LO, $urandom);
    send_word(CMD_DUMP_UP, $urandom);
    send_word(CMD_POP_LO, $urandom);
    send_word(CMD_POP_UP, $urandom);
    send_word(CMD_POP_LO, $urandom);
    send_word(CMD_POP_UP, $urandom);
    send_word(CMD_POP_LO, $urandom);
    send_word(CMD_POP_UP, $urandom);
  endtask

  // Fill the memory from both ends, push into a full memory, dump, empty it
  task automatic test_shared_full();
    while (lower_count + upper_count < DEPTH)
      send_word($urandom_range(0, 1) ? CMD_PUSH_UP : CMD_PUSH_LO, $urandom);
    send_word(CMD_PUSH_LO, $urandom);
    send_word(CMD_PUSH_UP, $urandom);
    send_word(CMD_DUMP_LO, $urandom);
    send_word(CMD_DUMP_UP, $urandom);
    // pause with nothing in flight before emptying
    wait_results_drained();
    while (lower_count + upper_count > 0)
      send_word((upper_count > 0 && (lower_count == 0 || $urandom_range(0, 1))) ?
                CMD_POP_UP : CMD_POP_LO, $urandom);
  endtask

  // One stack takes the whole memory: longest dump, overflow on the other side
  task automatic test_longest_dump(bit upper);
    while (lower_count + upper_count < DEPTH)
      send_word(upper ? CMD_PUSH_UP : CMD_PUSH_LO, $urandom);
    send_word(upper ? CMD_PUSH_LO : CMD_PUSH_UP, $urandom);
    send_word(upper ? CMD_DUMP_UP : CMD_DUMP_LO, $urandom);
    send_word(upper ? CMD_DUMP_LO : CMD_DUMP_UP, $urandom);
    while (lower_count + upper_count > 0)
      send_word(upper ? CMD_POP_UP : CMD_POP_LO, $urandom);
  endtask

  // Alternate filling and draining mixes with random content
  task automatic test_random_traffic();
    traffic_mix_t mix;
    int           seg_len;
    while (words_sent < STREAM_ITEMS) begin
      shuffle_pacing();
      mix     = traffic_mix_t'($urandom_range(0, 2));
      seg_len = $urandom_range(10, 40);
      repeat (seg_len) send_word(pick_command(mix), $urandom);
    end
  endtask

  // Result monitor: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < SHOW_MAX)
          $display("%0t: unexpected result data %0d status %0d last %0b",
                   $realtime, out_tdata, out_tuser, out_tlast);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.word || out_tuser !== want.status ||
            out_tlast !== want.last) begin
          if (mismatch_count < SHOW_MAX)
            $display("%0t: result mismatch: expected data %0d status %0d last %0b,",
                     $realtime, want.word, want.status, want.last,
                     " got data %0d status %0d last %0b",
                     out_tdata, out_tuser, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    lower_count = 0;
    upper_count = 0;
    foreach (mirror_mem[i]) mirror_mem[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_stacks();
    shuffle_pacing();
    test_extreme_values();
    shuffle_pacing();
    test_shared_full();
    shuffle_pacing();
    test_longest_dump(1'b0);
    shuffle_pacing();
    test_longest_dump(1'b1);
    test_random_traffic();

    // let the last results through, then allow for a trailing dump
    wait_results_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
